// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, step codes and the control store of the median sequencer.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CODE_W = 12;
  localparam int STEP_W = 3;
  localparam int COND_W = 2;

  // sequencer steps
  localparam logic [STEP_W-1:0] UC_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] UC_READ = 3'd1;
  localparam logic [STEP_W-1:0] UC_OLD  = 3'd2;
  localparam logic [STEP_W-1:0] UC_RM   = 3'd3;
  localparam logic [STEP_W-1:0] UC_INS  = 3'd4;
  localparam logic [STEP_W-1:0] UC_RPT  = 3'd5;

  // jump conditions
  localparam logic [COND_W-1:0] COND_NEXT     = 2'd0;
  localparam logic [COND_W-1:0] COND_DISPATCH = 2'd1;
  localparam logic [COND_W-1:0] COND_OUT_FREE = 2'd2;

  typedef struct packed {
    logic [STEP_W-1:0] next_step;
    logic [COND_W-1:0] cond;
    logic              take_in;
    logic              ram_rd;
    logic              ram_wr;
    logic              sort_rm;
    logic              sort_ins;
    logic              out_ld;
  } uc_word_t;

  typedef struct packed {
    logic rm;
    logic ins;
  } sort_ctrl_t;

  // control store
  function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
    uc_word_t w;
    w = '0;
    unique case (step)
      UC_IDLE: begin
        w.next_step = UC_READ;
        w.cond      = COND_DISPATCH;
        w.take_in   = 1'b1;
      end
      UC_READ: begin
        w.next_step = UC_OLD;
        w.cond      = COND_NEXT;
        w.ram_rd    = 1'b1;
      end
      UC_OLD: begin
        w.next_step = UC_RM;
        w.cond      = COND_NEXT;
        w.ram_wr    = 1'b1;
      end
      UC_RM: begin
        w.next_step = UC_INS;
        w.cond      = COND_NEXT;
        w.sort_rm   = 1'b1;
      end
      UC_INS: begin
        w.next_step = UC_IDLE;
        w.cond      = COND_NEXT;
        w.sort_ins  = 1'b1;
      end
      UC_RPT: begin
        w.next_step = UC_IDLE;
        w.cond      = COND_OUT_FREE;
        w.out_ld    = 1'b1;
      end
      default: begin
        w.next_step = UC_IDLE;
        w.cond      = COND_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/swm_ram.sv =====
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/swm_sorter.sv =====
// ----------------------------------------------------------------------------
// swm_sorter
// Row of cells holding the window contents in ascending order; one step
// removes a code, the next step inserts one, the middle cells give the median.
// ----------------------------------------------------------------------------
module swm_sorter #(
  parameter int WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swm_pkg::sort_ctrl_t        ctrl,
  input  logic [swm_pkg::CODE_W-1:0] old_code,
  input  logic [swm_pkg::CODE_W-1:0] new_code,
  output logic [swm_pkg::CODE_W-1:0] median_code
);

  localparam int MID_HI = WINDOW / 2;
  localparam int MID_LO = (WINDOW - 1) / 2;

  logic [swm_pkg::CODE_W-1:0] s_r     [WINDOW];
  logic [swm_pkg::CODE_W-1:0] rem_val [WINDOW];
  logic [swm_pkg::CODE_W-1:0] ins_val [WINDOW];
  logic [WINDOW-1:0]          gt;
  logic [swm_pkg::CODE_W:0]   mid_sum;

  // drop one copy of old_code, everything above it moves down
  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      rem_val[i] = (s_r[i] >= old_code) ? s_r[i+1] : s_r[i];
    end
    rem_val[WINDOW-1] = s_r[WINDOW-1];
  end

  // top cell is vacant after a removal
  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      gt[i] = s_r[i] > new_code;
    end
    gt[WINDOW-1] = 1'b1;
    ins_val[0] = gt[0] ? new_code : s_r[0];
    for (int i = 1; i < WINDOW; i++) begin
      ins_val[i] = gt[i] ? (gt[i-1] ? s_r[i-1] : new_code) : s_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        s_r[i] <= '0;
      end
    end else if (ctrl.rm) begin
      s_r <= rem_val;
    end else if (ctrl.ins) begin
      s_r <= ins_val;
    end
  end

  assign mid_sum     = {1'b0, s_r[MID_HI]} + {1'b0, s_r[MID_LO]};
  assign median_code = mid_sum[swm_pkg::CODE_W:1];

endmodule

// ===== hw/rtl/sliding_window_median_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Median of the last WINDOW converter samples, run by a microcoded sequencer.
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_func, in_sample
//   out      output     out_valid, out_stall, out_median_code
//
// A store word, once accepted, runs ring read, ring write, removal of the old
// code from the sorted row and insertion before the next word is accepted.
// A report word loads the output register once no earlier result is held.
// Reset clears the ring valid bits and the sorted row at once, no sweep.
// Stores go on while a result waits at the output register.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
  parameter int WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [swm_pkg::CODE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [swm_pkg::CODE_W-1:0] out_median_code
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [swm_pkg::STEP_W-1:0] upc_r;
  logic [swm_pkg::STEP_W-1:0] upc_nxt;
  swm_pkg::uc_word_t          uw;
  logic                       in_acc;
  logic                       out_free;
  logic                       out_load;

  logic [PTR_W-1:0]           wp_r;
  logic [PTR_W-1:0]           wp_nxt;
  logic [WINDOW-1:0]          vld_r;
  logic [WINDOW-1:0]          vld_nxt;
  logic [swm_pkg::CODE_W-1:0] sample_r;
  logic [swm_pkg::CODE_W-1:0] old_r;
  logic [swm_pkg::CODE_W-1:0] ram_rdata;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [swm_pkg::CODE_W-1:0] out_code_r;
  logic [swm_pkg::CODE_W-1:0] median_code;
  swm_pkg::sort_ctrl_t        sort_ctrl;

  assign uw       = swm_pkg::uc_rom(upc_r);
  assign in_stall = !uw.take_in;
  assign in_acc   = in_valid && uw.take_in;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = uw.out_ld && out_free;

  // sequencer
  always_comb begin
    upc_nxt = upc_r;
    unique case (uw.cond)
      swm_pkg::COND_NEXT: begin
        upc_nxt = uw.next_step;
      end
      swm_pkg::COND_DISPATCH: begin
        if (in_acc) begin
          upc_nxt = in_func ? swm_pkg::UC_RPT : uw.next_step;
        end
      end
      swm_pkg::COND_OUT_FREE: begin
        if (out_free) begin
          upc_nxt = uw.next_step;
        end
      end
      default: begin
        upc_nxt = swm_pkg::UC_IDLE;
      end
    endcase
  end

  // ring pointer and entry valid bits
  always_comb begin
    wp_nxt  = wp_r;
    vld_nxt = vld_r;
    if (uw.ram_wr) begin
      wp_nxt        = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
      vld_nxt[wp_r] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= swm_pkg::UC_IDLE;
      wp_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      wp_r        <= wp_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    if (uw.ram_wr) begin
      old_r <= vld_r[wp_r] ? ram_rdata : '0;
    end
    if (out_load) begin
      out_code_r <= median_code;
    end
  end

  swm_ram #(
    .WIDTH (swm_pkg::CODE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (uw.ram_wr),
    .wr_addr (wp_r),
    .wr_data (sample_r),
    .rd_en   (uw.ram_rd),
    .rd_addr (wp_r),
    .rd_data (ram_rdata)
  );

  assign sort_ctrl.rm  = uw.sort_rm;
  assign sort_ctrl.ins = uw.sort_ins;

  swm_sorter #(
    .WINDOW (WINDOW)
  ) u_sorter (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (sort_ctrl),
    .old_code    (old_r),
    .new_code    (sample_r),
    .median_code (median_code)
  );

  assign out_valid       = out_valid_r;
  assign out_median_code = out_code_r;

endmodule

// ===== tb/sliding_window_median_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit_test
// Self-checking bench for the sliding window median unit. A short table of
// store and report words opens the run, then random words follow with bursts
// of idling on both channels, a long output hold-off and a drain pause. Every
// report is scored against a table median or an in-bench sample ring model.
// ----------------------------------------------------------------------------
module sliding_window_median_unit_test;

  localparam int WINDOW = 32;
  localparam int CW = swm_pkg::CODE_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic FUNC_STORE  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef struct packed {
    logic          func;
    logic [CW-1:0] sample;
    logic          known;
    logic [CW-1:0] median;
  } probe_row_t;

  localparam int PROBE_N = 22;

  // known medians only while zeros from reset still hold the middle
  localparam probe_row_t PROBE_ROWS [PROBE_N] = '{
    '{FUNC_REPORT, 12'd0,    1'b1, 12'd0},
    '{FUNC_REPORT, 12'hFFF,  1'b1, 12'd0},
    '{FUNC_STORE,  12'hFFF,  1'b0, 12'd0},
    '{FUNC_REPORT, 12'd0,    1'b1, 12'd0},
    '{FUNC_STORE,  12'd0,    1'b0, 12'd0},
    '{FUNC_STORE,  12'hFFF,  1'b0, 12'd0},
    '{FUNC_STORE,  12'd1,    1'b0, 12'd0},
    '{FUNC_STORE,  12'h800,  1'b0, 12'd0},
    '{FUNC_STORE,  12'hAAA,  1'b0, 12'd0},
    '{FUNC_STORE,  12'h555,  1'b0, 12'd0},
    '{FUNC_REPORT, 12'h123,  1'b1, 12'd0},
    '{FUNC_REPORT, 12'hEDC,  1'b1, 12'd0},
    '{FUNC_STORE,  12'hFFE,  1'b0, 12'd0},
    '{FUNC_STORE,  12'h7FF,  1'b0, 12'd0},
    '{FUNC_STORE,  12'h001,  1'b0, 12'd0},
    '{FUNC_STORE,  12'hF0F,  1'b0, 12'd0},
    '{FUNC_STORE,  12'h0F0,  1'b0, 12'd0},
    '{FUNC_REPORT, 12'd0,    1'b0, 12'd0},
    '{FUNC_STORE,  12'hC00,  1'b0, 12'd0},
    '{FUNC_STORE,  12'h003,  1'b0, 12'd0},
    '{FUNC_REPORT, 12'hFFF,  1'b0, 12'd0},
    '{FUNC_REPORT, 12'd0,    1'b0, 12'd0}
  };

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_func = FUNC_STORE;
  logic [CW-1:0] in_sample = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] out_median_code;

  logic [CW-1:0] ring_codes [WINDOW];
  int            ring_wr_ptr;
  logic [CW-1:0] median_due_q [$];
  logic [CW-1:0] median_due;
  logic [CW-1:0] cluster_base;
  int            mismatch_count = 0;
  int            cycle_count;
  bit            sender_idle_on = 1'b0;
  bit            receiver_idle_on = 1'b0;
  bit            hold_req = 1'b0;
  int            hold_cycles = 0;

  sliding_window_median_unit #(.WINDOW(WINDOW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median_code(out_median_code)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CW-1:0] median_of_ring();
    logic [CW-1:0] s [WINDOW];
    logic [CW-1:0] key;
    logic [CW:0]   sum;
    int i;
    int k;
    for (i = 0; i < WINDOW; i++) s[i] = ring_codes[i];
    for (i = 1; i < WINDOW; i++) begin
      key = s[i];
      k = i;
      while (k > 0 && s[k-1] > key) begin
        s[k] = s[k-1];
        k--;
      end
      s[k] = key;
    end
    if (WINDOW % 2 == 1) return s[(WINDOW-1)/2];
    sum = {1'b0, s[WINDOW/2]} + {1'b0, s[WINDOW/2-1]};
    return sum[CW:1];
  endfunction

  function automatic logic [CW-1:0] pick_sample();
    logic [CW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = CW'($urandom_range(0, 4095));
      4, 5: begin
        case ($urandom_range(0, 3))
          0: v = 12'h000;
          1: v = 12'hFFF;
          2: v = 12'h800;
          default: v = 12'h7FF;
        endcase
      end
      default: v = CW'(cluster_base + $urandom_range(0, 15) - 8);
    endcase
    return v;
  endfunction

  task automatic offer_word(input logic func, input logic [CW-1:0] sample,
                            input logic known, input logic [CW-1:0] median);
    int gap;
    in_valid  <= 1'b1;
    in_func   <= func;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (func == FUNC_STORE) begin
      ring_codes[ring_wr_ptr] = sample;
      ring_wr_ptr = (ring_wr_ptr == WINDOW - 1) ? 0 : ring_wr_ptr + 1;
    end else begin
      median_due_q.push_back(known ? median : median_of_ring());
    end
    gap = (sender_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_words(input int count, input int report_pct);
    int n;
    logic f;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) cluster_base = CW'($urandom_range(0, 4095));
      f = ($urandom_range(0, 99) < report_pct) ? FUNC_REPORT : FUNC_STORE;
      offer_word(f, pick_sample(), 1'b0, '0);
    end
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_due_q.size() == 0) begin
        $error("unexpected word: out_median_code actual %0d", out_median_code);
        mismatch_count++;
      end else begin
        median_due = median_due_q.pop_front();
        if (out_median_code !== median_due) begin
          $error("out_median_code expected %0d actual %0d", median_due, out_median_code);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int r;
    for (r = 0; r < WINDOW; r++) ring_codes[r] = '0;
    ring_wr_ptr = 0;
    cluster_base = CW'($urandom_range(0, 4095));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    for (r = 0; r < PROBE_N; r++) begin
      offer_word(PROBE_ROWS[r].func, PROBE_ROWS[r].sample,
                 PROBE_ROWS[r].known, PROBE_ROWS[r].median);
    end

    random_words(350, 30);

    // long output hold-off while reports keep coming
    sender_idle_on = 1'b0;
    hold_cycles = 300;
    hold_req = 1'b1;
    random_words(24, 70);

    // drain before going on
    in_valid <= 1'b0;
    while (median_due_q.size() != 0) @(posedge clk);

    sender_idle_on = 1'b1;
    random_words(500, 30);

    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    random_words(400, 30);

    in_valid <= 1'b0;
    while (median_due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
